// ===== hw/rtl/tgr_pkg.sv =====
// ----------------------------------------------------------------------------
// tgr_pkg
// Shared constants, codes and stage types of the text glyph row renderer.
// ----------------------------------------------------------------------------
package tgr_pkg;

    localparam int GLYPH_ROWS      = 16;
    localparam int PALETTE_ENTRIES = 256;

    localparam int FONT_DEPTH = 256 * GLYPH_ROWS;
    localparam int FONT_AW    = $clog2(FONT_DEPTH);
    localparam int PAL_DEPTH  = PALETTE_ENTRIES * 3;
    localparam int PAL_IW     = $clog2(PAL_DEPTH);
    localparam int PAL_AW     = $clog2(PALETTE_ENTRIES);

    // entry = (index * DIV3_MUL) >> DIV3_SHIFT, exact for index below 2**DIV3_SHIFT
    localparam int DIV3_SHIFT = 11;
    localparam int DIV3_MUL   = (2 ** DIV3_SHIFT + 2) / 3;
    localparam int DIV3_MW    = $clog2(DIV3_MUL + 1);
    localparam int DIV3_W     = PAL_IW + DIV3_MW;

    localparam int PIXELS = 8;
    localparam int PIX_W  = $clog2(PIXELS);
    localparam logic [PIX_W-1:0] PIX_LAST = PIX_W'(PIXELS - 1);

    localparam logic [1:0] COMP_RED   = 2'd0;
    localparam logic [1:0] COMP_GREEN = 2'd1;
    localparam logic [1:0] COMP_BLUE  = 2'd2;

    typedef enum logic [1:0] {
        OP_FONT   = 2'd0,
        OP_PAL    = 2'd1,
        OP_RENDER = 2'd2
    } op_t;

    typedef struct packed {
        logic               font_we;
        logic               pal_we;
        logic               render;
        logic [FONT_AW-1:0] font_addr;
        logic [7:0]         value;
        logic [PAL_AW-1:0]  pal_entry;
        logic [1:0]         pal_comp;
        logic [3:0]         fg_idx;
        logic [3:0]         bg_idx;
        logic               row_ok;
    } front_t;

    typedef struct packed {
        logic [7:0] bits;
        logic       row_ok;
        logic [5:0] fg_r;
        logic [5:0] fg_g;
        logic [5:0] fg_b;
        logic [5:0] bg_r;
        logic [5:0] bg_g;
        logic [5:0] bg_b;
    } lookup_t;

    typedef struct packed {
        logic [7:0]  bits;
        logic [23:0] fg;
        logic [23:0] bg;
    } row_t;

endpackage

// ===== hw/rtl/tgr_front.sv =====
// ----------------------------------------------------------------------------
// tgr_front
// Input stage: decodes a beat into store writes or a render lookup request.
// ----------------------------------------------------------------------------
module tgr_front
    import tgr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // char_code, attribute, glyph_row, load_index, load_value
    input  logic [1:0]   s_tuser,   // op
    output logic         out_valid,
    output front_t       out_item,
    input  logic         out_ready
);

    logic               valid_reg;
    front_t             item_reg;
    front_t             item_next;
    op_t                op;
    logic [7:0]         code;
    logic [7:0]         attr;
    logic [3:0]         row;
    logic [11:0]        lidx;
    logic [7:0]         lval;
    logic [PAL_IW-1:0]  pidx;
    logic [DIV3_W-1:0]  prod;
    logic [PAL_AW-1:0]  entry;
    logic [PAL_IW-1:0]  entry3;
    logic               font_ok;
    logic               pal_ok;

    assign op   = op_t'(s_tuser);
    assign code = s_tdata[7:0];
    assign attr = s_tdata[15:8];
    assign row  = s_tdata[19:16];
    assign lidx = s_tdata[31:20];
    assign lval = s_tdata[39:32];

    assign pidx    = PAL_IW'(lidx);
    assign prod    = DIV3_W'(pidx) * DIV3_W'(DIV3_MUL);
    assign entry   = PAL_AW'(prod >> DIV3_SHIFT);
    assign entry3  = PAL_IW'({entry, 1'b0}) + PAL_IW'(entry);
    assign font_ok = 32'(lidx) < 32'(FONT_DEPTH);
    assign pal_ok  = 32'(lidx) < 32'(PAL_DEPTH);

    always_comb
    begin
        item_next           = '0;
        item_next.value     = lval;
        item_next.pal_entry = entry;
        item_next.pal_comp  = 2'(pidx - entry3);
        item_next.fg_idx    = attr[3:0];
        item_next.bg_idx    = attr[7:4];
        item_next.row_ok    = 32'(row) < 32'(GLYPH_ROWS);
        item_next.font_addr = FONT_AW'(lidx);
        unique case (op)
            OP_FONT:
            begin
                item_next.font_we = font_ok;
            end
            OP_PAL:
            begin
                item_next.pal_we = pal_ok;
            end
            OP_RENDER:
            begin
                item_next.render    = 1'b1;
                item_next.font_addr = FONT_AW'(FONT_AW'(code) * FONT_AW'(GLYPH_ROWS))
                                    + FONT_AW'(row);
            end
            default:
            begin
                item_next.render = 1'b0;
            end
        endcase
    end

    assign s_tready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== hw/rtl/tgr_store.sv =====
// ----------------------------------------------------------------------------
// tgr_store
// Font and palette memories: takes writes and registers render lookups.
// ----------------------------------------------------------------------------
module tgr_store
    import tgr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  front_t  in_item,
    output logic    in_ready,
    output logic    out_valid,
    output lookup_t out_item,
    input  logic    out_ready
);

    logic [7:0] font_mem  [FONT_DEPTH];
    logic [5:0] pal_r_mem [PALETTE_ENTRIES];
    logic [5:0] pal_g_mem [PALETTE_ENTRIES];
    logic [5:0] pal_b_mem [PALETTE_ENTRIES];

    logic              valid_reg;
    logic [7:0]        bits_reg;
    logic              row_ok_reg;
    logic [5:0]        fg_r_reg;
    logic [5:0]        fg_g_reg;
    logic [5:0]        fg_b_reg;
    logic [5:0]        bg_r_reg;
    logic [5:0]        bg_g_reg;
    logic [5:0]        bg_b_reg;
    logic              stage_free;
    logic              rd_en;
    logic              font_wr;
    logic              pal_wr;
    logic [PAL_AW-1:0] fg_addr;
    logic [PAL_AW-1:0] bg_addr;

    assign stage_free = !valid_reg || out_ready;
    assign in_ready   = !in_item.render || stage_free;
    assign rd_en      = in_valid && in_item.render && stage_free;
    assign font_wr    = in_valid && in_item.font_we;
    assign pal_wr     = in_valid && in_item.pal_we;
    assign fg_addr    = PAL_AW'(in_item.fg_idx);
    assign bg_addr    = PAL_AW'(in_item.bg_idx);

    always_ff @(posedge clk)
    begin
        if (font_wr)
        begin
            font_mem[in_item.font_addr] <= in_item.value;
        end
        if (rd_en)
        begin
            bits_reg   <= font_mem[in_item.font_addr];
            row_ok_reg <= in_item.row_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pal_wr && in_item.pal_comp == COMP_RED)
        begin
            pal_r_mem[in_item.pal_entry] <= in_item.value[5:0];
        end
        if (rd_en)
        begin
            fg_r_reg <= pal_r_mem[fg_addr];
            bg_r_reg <= pal_r_mem[bg_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pal_wr && in_item.pal_comp == COMP_GREEN)
        begin
            pal_g_mem[in_item.pal_entry] <= in_item.value[5:0];
        end
        if (rd_en)
        begin
            fg_g_reg <= pal_g_mem[fg_addr];
            bg_g_reg <= pal_g_mem[bg_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pal_wr && in_item.pal_comp == COMP_BLUE)
        begin
            pal_b_mem[in_item.pal_entry] <= in_item.value[5:0];
        end
        if (rd_en)
        begin
            fg_b_reg <= pal_b_mem[fg_addr];
            bg_b_reg <= pal_b_mem[bg_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (stage_free)
        begin
            valid_reg <= in_valid && in_item.render;
        end
    end

    assign out_valid       = valid_reg;
    assign out_item.bits   = bits_reg;
    assign out_item.row_ok = row_ok_reg;
    assign out_item.fg_r   = fg_r_reg;
    assign out_item.fg_g   = fg_g_reg;
    assign out_item.fg_b   = fg_b_reg;
    assign out_item.bg_r   = bg_r_reg;
    assign out_item.bg_g   = bg_g_reg;
    assign out_item.bg_b   = bg_b_reg;

    a_no_rd_on_font_wr: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && font_wr))
        else $error("font read and write in one cycle");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready |=> valid_reg && $stable(bits_reg) && $stable(fg_r_reg))
        else $error("lookup stage lost data on stall");

endmodule

// ===== hw/rtl/tgr_shade.sv =====
// ----------------------------------------------------------------------------
// tgr_shade
// Colour stage: widens palette components to RGB and masks rows past the glyph.
// ----------------------------------------------------------------------------
module tgr_shade
    import tgr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  lookup_t in_item,
    output logic    in_ready,
    output logic    out_valid,
    output row_t    out_item,
    input  logic    out_ready
);

    logic valid_reg;
    row_t item_reg;
    row_t item_next;

    always_comb
    begin
        item_next.bits = in_item.row_ok ? in_item.bits : 8'h00;
        item_next.fg   = {in_item.fg_r, 2'b00, in_item.fg_g, 2'b00, in_item.fg_b, 2'b00};
        item_next.bg   = {in_item.bg_r, 2'b00, in_item.bg_g, 2'b00, in_item.bg_b, 2'b00};
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== hw/rtl/tgr_serial.sv =====
// ----------------------------------------------------------------------------
// tgr_serial
// Pixel serialiser: emits one glyph row as eight pixel beats, MSB first.
// ----------------------------------------------------------------------------
module tgr_serial
    import tgr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  row_t        in_item,
    output logic        in_ready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // pixel_color
    output logic        m_tlast     // last_pixel
);

    logic             valid_reg;
    logic             valid_next;
    logic [PIX_W-1:0] cnt_reg;
    logic [PIX_W-1:0] cnt_next;
    logic [7:0]       bits_reg;
    logic [7:0]       bits_next;
    logic [23:0]      fg_reg;
    logic [23:0]      bg_reg;
    logic             take;
    logic             done;
    logic             load;

    assign take     = valid_reg && m_tready;
    assign done     = take && cnt_reg == PIX_LAST;
    assign in_ready = !valid_reg || done;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        bits_next  = bits_reg;
        priority if (load)
        begin
            valid_next = 1'b1;
            cnt_next   = '0;
            bits_next  = in_item.bits;
        end
        else if (take)
        begin
            valid_next = !done;
            cnt_next   = cnt_reg + PIX_W'(1);
            bits_next  = {bits_reg[6:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        if (load)
        begin
            fg_reg <= in_item.fg;
            bg_reg <= in_item.bg;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = bits_reg[7] ? fg_reg : bg_reg;
    assign m_tlast  = cnt_reg == PIX_LAST;

    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !valid_reg || cnt_reg == '0)
        else $error("row did not restart after last pixel");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !m_tready |=> valid_reg && $stable(cnt_reg) && $stable(bits_reg))
        else $error("serialiser advanced while stalled");

endmodule

// ===== hw/rtl/text_glyph_row_renderer_core.sv =====
// ----------------------------------------------------------------------------
// text_glyph_row_renderer_core
// Text-mode pixel generator with loadable font and palette stores.
//
// Input channel s_*: each beat carries an op in s_tuser. Font load and palette
// load beats write the stores and produce no output; one is taken per cycle
// while s_tready is high. A render beat looks up a glyph row and two palette
// entries and yields eight pixel beats on m_*, left to right, with m_tlast on
// the eighth. Its first pixel follows the front, lookup, shade and serialiser
// registers. The serialiser emits one pixel per clock while m_tready is high
// and loads the next row as the last pixel is taken, so pixel beats run
// without gaps; it takes no new row before then. Loads behind a render still
// enter each cycle until the pipeline fills.
// Reset clears all stage valid bits; store contents are undefined until
// written. When m_tready is low, every stage holds its beat and s_tready falls
// once the stages ahead are full.
// ----------------------------------------------------------------------------
module text_glyph_row_renderer_core
    import tgr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // char_code[7:0], attribute[15:8], glyph_row[19:16],
                                   // load_index[31:20], load_value[39:32]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // pixel_color[23:0]
    output logic        m_tlast    // last_pixel
);

    logic    front_valid;
    front_t  front_item;
    logic    front_ready;
    logic    look_valid;
    lookup_t look_item;
    logic    look_ready;
    logic    row_valid;
    row_t    row_item;
    logic    row_ready;

    tgr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .out_valid (front_valid),
        .out_item  (front_item),
        .out_ready (front_ready)
    );

    tgr_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_item   (front_item),
        .in_ready  (front_ready),
        .out_valid (look_valid),
        .out_item  (look_item),
        .out_ready (look_ready)
    );

    tgr_shade u_shade (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (look_valid),
        .in_item   (look_item),
        .in_ready  (look_ready),
        .out_valid (row_valid),
        .out_item  (row_item),
        .out_ready (row_ready)
    );

    tgr_serial u_serial (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (row_valid),
        .in_item  (row_item),
        .in_ready (row_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== tb/text_glyph_row_renderer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_glyph_row_renderer_checker
// Watches both stream channels of the glyph row renderer. It keeps its own
// image of the font and palette stores, built from accepted load beats, and
// turns each accepted render beat into eight expected pixels. Every output
// beat is compared with the oldest expected pixel.
// ----------------------------------------------------------------------------
module text_glyph_row_renderer_checker
    import tgr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending,
    output int          pixel_count
);

    typedef struct packed {
        logic [23:0] colour;
        logic        last;
    } pixel_t;

    logic [7:0] glyph_bytes [FONT_DEPTH];
    logic [5:0] dac_levels [PAL_DEPTH];
    pixel_t     expected_pixels [$];

    function automatic logic [23:0] entry_rgb(input logic [3:0] entry);
        int base;
        base = int'(entry) * 3;
        return {dac_levels[base], 2'b00, dac_levels[base + 1], 2'b00,
                dac_levels[base + 2], 2'b00};
    endfunction

    task automatic paint_row(input logic [7:0] code, input logic [7:0] attr,
                             input logic [3:0] row);
        logic [23:0] fg;
        logic [23:0] bg;
        logic [7:0]  bits;
        pixel_t      px;
        fg   = entry_rgb(attr[3:0]);
        bg   = entry_rgb(attr[7:4]);
        bits = (int'(row) < GLYPH_ROWS) ? glyph_bytes[int'(code) * GLYPH_ROWS + int'(row)]
                                        : 8'h00;
        for (int x = 0; x < PIXELS; x++)
        begin
            px.colour = bits[7 - x] ? fg : bg;
            px.last   = (x == PIXELS - 1);
            expected_pixels.push_back(px);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        pixel_t      want;
        logic [11:0] lidx;
        if (!rst_n)
        begin
            expected_pixels.delete();
            fail_count  = 0;
            pixel_count = 0;
            pending    <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: unexpected pixel beat: expected none, got colour %06h last %0b",
                             $time, m_tdata, m_tlast);
                    fail_count++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    pixel_count++;
                    if (m_tdata !== want.colour)
                    begin
                        $display("%0t: pixel colour mismatch: expected %06h, got %06h",
                                 $time, want.colour, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $display("%0t: last pixel flag mismatch: expected %0b, got %0b",
                                 $time, want.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                lidx = s_tdata[31:20];
                unique case (s_tuser)
                    OP_FONT:
                        if (int'(lidx) < FONT_DEPTH)
                            glyph_bytes[lidx] = s_tdata[39:32];
                    OP_PAL:
                        if (int'(lidx) < PAL_DEPTH)
                            dac_levels[lidx] = s_tdata[37:32];
                    OP_RENDER:
                        paint_row(s_tdata[7:0], s_tdata[15:8], s_tdata[19:16]);
                    default:
                        ;
                endcase
            end
            pending <= expected_pixels.size();
        end
    end

endmodule

// ===== tb/text_glyph_row_renderer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_glyph_row_renderer_core_tb
// Stimulus and verdict for the glyph row renderer. A directed opening covers
// store extremes, masking of palette values, ignored loads and the spare op;
// random load-and-render sequences then run under changing sender gaps and
// receiver back-pressure. Renders only touch font rows and palette entries
// already written.
// ----------------------------------------------------------------------------
module text_glyph_row_renderer_core_tb
    import tgr_pkg::*;
();

    localparam int         CYCLE_LIMIT = 400000;
    localparam int         PHASE_BEATS = 50;
    localparam logic [1:0] OP_SPARE    = 2'd3;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    int fail_count;
    int pending;
    int pixel_count;

    int idle_pct    = 0;
    int stall_pct   = 0;
    int cycles      = 0;
    int phase_beats = 0;
    int font_loads  = 0;
    int pal_loads   = 0;
    int renders     = 0;

    bit          font_known [FONT_DEPTH];
    bit          comp_known [PAL_DEPTH];
    logic [11:0] font_rows [$];

    text_glyph_row_renderer_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    text_glyph_row_renderer_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .pending     (pending),
        .pixel_count (pixel_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    task automatic send_beat(input logic [1:0] op, input logic [7:0] code,
                             input logic [7:0] attr, input logic [3:0] row,
                             input logic [11:0] lidx, input logic [7:0] lval);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {lval, lidx, row, attr, code};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic put_font(input logic [11:0] addr, input logic [7:0] val);
        send_beat(OP_FONT, 8'($urandom), 8'($urandom), 4'($urandom), addr, val);
        if (!font_known[addr])
        begin
            font_known[addr] = 1'b1;
            font_rows.push_back(addr);
        end
        font_loads++;
        phase_beats++;
    endtask

    task automatic put_comp(input logic [11:0] idx, input logic [7:0] val);
        send_beat(OP_PAL, 8'($urandom), 8'($urandom), 4'($urandom), idx, val);
        if (int'(idx) < PAL_DEPTH)
        begin
            comp_known[idx] = 1'b1;
            pal_loads++;
            phase_beats++;
        end
    endtask

    task automatic put_entry(input int entry);
        for (int c = 0; c < 3; c++)
            put_comp(12'(entry * 3 + c), 8'($urandom));
    endtask

    task automatic put_row(input logic [7:0] code, input logic [7:0] attr,
                           input logic [3:0] row);
        send_beat(OP_RENDER, code, attr, row, 12'($urandom), 8'($urandom));
        renders++;
        phase_beats++;
    endtask

    function automatic bit entry_ready(input int entry);
        return comp_known[entry * 3] && comp_known[entry * 3 + 1] && comp_known[entry * 3 + 2];
    endfunction

    function automatic int pick_entry();
        int entry;
        for (int t = 0; t < 16; t++)
        begin
            entry = $urandom_range(15);
            if (entry_ready(entry))
                return entry;
        end
        return -1;
    endfunction

    task automatic run_phase();
        int          kind;
        int          fg;
        int          bg;
        int          reps;
        logic [11:0] addr;
        phase_beats = 0;
        while (phase_beats < PHASE_BEATS)
        begin
            kind = $urandom_range(99);
            if (kind < 55)
            begin
                fg = $urandom_range(15);
                bg = $urandom_range(15);
                if (!entry_ready(fg) || $urandom_range(3) == 0)
                    put_entry(fg);
                if (!entry_ready(bg) || $urandom_range(3) == 0)
                    put_entry(bg);
                addr = 12'($urandom);
                if (!font_known[addr] || $urandom_range(2) == 0)
                    put_font(addr, 8'($urandom));
                reps = $urandom_range(1, 3);
                repeat (reps)
                    put_row(addr[11:4], {4'(bg), 4'(fg)}, addr[3:0]);
            end
            else if (kind < 70)
            begin
                fg = pick_entry();
                bg = pick_entry();
                if (fg >= 0 && bg >= 0 && font_rows.size() > 0)
                begin
                    addr = font_rows[$urandom_range(font_rows.size() - 1)];
                    put_row(addr[11:4], {4'(bg), 4'(fg)}, addr[3:0]);
                end
            end
            else if (kind < 80)
                put_font(12'($urandom), 8'($urandom));
            else if (kind < 90)
                put_comp(12'($urandom_range(PAL_DEPTH - 1)), 8'($urandom));
            else if (kind < 95)
                put_comp(12'($urandom_range(4095, PAL_DEPTH)), 8'($urandom));
            else
                send_beat(OP_SPARE, 8'($urandom), 8'($urandom), 4'($urandom),
                          12'($urandom), 8'($urandom));
        end
    endtask

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: run stopped at the cycle limit with %0d pixels outstanding",
                 $time, pending);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int idle_tab [4];
        int stall_tab [4];
        idle_tab  = '{0, 68, 0, 22};
        stall_tab = '{0, 0, 68, 22};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // black, full-scale and last entries, with bits above the DAC width set
        put_comp(12'd0, 8'hC0);
        put_comp(12'd1, 8'h00);
        put_comp(12'd2, 8'h40);
        put_comp(12'd45, 8'hFF);
        put_comp(12'd46, 8'h3F);
        put_comp(12'd47, 8'h7F);
        put_comp(12'd765, 8'hAA);
        put_comp(12'd766, 8'h55);
        put_comp(12'd767, 8'h2A);
        // beyond the palette: dropped
        put_comp(12'(PAL_DEPTH), 8'hFF);
        put_comp(12'hFFF, 8'hFF);
        put_font(12'h000, 8'h00);
        put_font(12'hFFF, 8'hFF);
        put_font(12'h5A7, 8'hA5);
        put_font(12'h5A8, 8'h81);
        put_row(8'h00, 8'hF0, 4'd0);
        put_row(8'hFF, 8'h0F, 4'd15);
        put_row(8'h5A, 8'hF0, 4'd7);
        put_row(8'h5A, 8'h0F, 4'd8);
        put_row(8'h5A, 8'h00, 4'd7);
        send_beat(OP_SPARE, 8'hFF, 8'hFF, 4'hF, 12'hFFF, 8'hFF);
        put_comp(12'd45, 8'h15);
        put_row(8'hFF, 8'hFF, 4'd15);

        for (int p = 0; p < 4; p++)
        begin
            idle_pct  = idle_tab[p];
            stall_pct = stall_tab[p];
            run_phase();
        end
        s_tvalid <= 1'b0;
        stall_pct = 22;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("covered %0d font loads, %0d palette loads and %0d row renders",
                 font_loads, pal_loads, renders);
        $display("%0d pixels compared across gap-free, sender-idle, stalled and mixed phases",
                 pixel_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
